/* hw/rtl/stt_pkg.sv */
// ---------------------------------------------------------------------------
// stt_pkg: shared types and constants for the sparse triplet transpose
// Entry format of the sorting chain, cell control and register indexes.
// ---------------------------------------------------------------------------
`default_nettype none

package stt_pkg;

    localparam int MAX_TERMS  = 16;
    localparam int IDX_W      = 12;
    localparam int VALUE_W    = 32;
    localparam int CFG_W      = 13;
    localparam int CFG_IDX_W  = 1;
    localparam int TDATA_W    = 56;

    localparam logic [CFG_IDX_W-1:0] REG_MATRIX_ROWS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MATRIX_COLS = 1'd1;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [IDX_W-1:0]   col;
        logic [IDX_W-1:0]   row;
    } stt_entry_t;

    typedef struct packed {
        logic ins;
        logic pop;
    } stt_ctrl_t;

endpackage

`default_nettype wire

/* hw/rtl/stt_cell.sv */
// ---------------------------------------------------------------------------
// stt_cell: one slot of the column-sorted triple chain
// Inserts a new triple in column order (stable), shifts right on insert
// and shifts left on pop.
// ---------------------------------------------------------------------------
`default_nettype none

module stt_cell (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire stt_pkg::stt_ctrl_t ctrl,
    input  wire stt_pkg::stt_entry_t new_ent,
    input  wire stt_pkg::stt_entry_t left_ent,
    input  wire logic               left_valid,
    input  wire logic               left_gt,
    input  wire stt_pkg::stt_entry_t right_ent,
    input  wire logic               right_valid,
    output stt_pkg::stt_entry_t     ent,
    output logic                    valid,
    output logic                    gt
);
    import stt_pkg::*;

    stt_entry_t ent_reg, ent_next;
    logic       valid_reg, valid_next;

    // new triple goes ahead of this slot when it is empty or holds a larger column
    assign gt    = !valid_reg || (ent_reg.col > new_ent.col);
    assign ent   = ent_reg;
    assign valid = valid_reg;

    always_comb begin
        ent_next   = ent_reg;
        valid_next = valid_reg;
        if (ctrl.pop) begin
            ent_next   = right_ent;
            valid_next = right_valid;
        end else if (ctrl.ins) begin
            if (left_valid && left_gt) begin
                // make room: take the neighbor's triple
                ent_next   = left_ent;
                valid_next = 1'b1;
            end else if (gt && !left_gt) begin
                ent_next   = new_ent;
                valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        ent_reg <= ent_next;
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/sparse_triplet_transpose.sv */
// ---------------------------------------------------------------------------
// sparse_triplet_transpose: transposes a list of sparse matrix triples
// Triples are sorted by column on arrival in a chain of cells; after the
// last request the chain drains from its head, row and column swapped.
// ---------------------------------------------------------------------------
//  channel  dir  fields (tdata low bit up)            end marker
//  s_       in   row[11:0] col[23:12] value[55:24]    s_tlast starts drain
//  m_       out  row[11:0] col[23:12] value[55:24]    m_tlast on final
//  cfg_     in   index 0 rows, 1 cols                 -
//
//  Loading takes one request per cycle; each stored triple moves into its
//  sorted slot in that cycle. Draining gives one result per cycle from the
//  head cell while m_tready is high, and s_tready stays low after loading
//  until the final kept triple is taken or the chain is found empty.
//  m_tready low holds the head cell; s_tready is low while draining.
//  Reset clears the cell valid bits and returns to loading; no sweep.
// ---------------------------------------------------------------------------
`default_nettype none

module sparse_triplet_transpose (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    input  wire logic [stt_pkg::TDATA_W-1:0]  s_tdata,   // in_row, in_col, in_value
    input  wire logic                         s_tlast,
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    output logic [stt_pkg::TDATA_W-1:0]       m_tdata,   // out_row, out_col, out_value
    output logic                              m_tlast,
    input  wire logic                         cfg_wr_en,
    input  wire logic [stt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [stt_pkg::CFG_W-1:0]    cfg_wr_data
);
    import stt_pkg::*;

    localparam logic PH_LOAD = 1'b0;
    localparam logic PH_EMIT = 1'b1;

    logic            phase_reg, phase_next;
    logic [CFG_W-1:0] matrix_cols_reg;

    stt_entry_t new_ent;
    stt_ctrl_t  ctrl;
    logic       accept, pop;

    stt_entry_t ent_a [MAX_TERMS+1];
    logic       vld_a [MAX_TERMS+1];
    logic       gt_a  [MAX_TERMS];
    logic [MAX_TERMS-1:0] vld_vec;

    assign new_ent.row   = s_tdata[IDX_W-1:0];
    assign new_ent.col   = s_tdata[2*IDX_W-1:IDX_W];
    assign new_ent.value = s_tdata[2*IDX_W+VALUE_W-1:2*IDX_W];

    assign s_tready = (phase_reg == PH_LOAD);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = (phase_reg == PH_EMIT) && vld_a[0];
    assign pop      = m_tvalid && m_tready;

    // drop when full or column outside the matrix
    assign ctrl.ins = accept && !vld_a[MAX_TERMS-1]
                      && ({1'b0, new_ent.col} < matrix_cols_reg);
    assign ctrl.pop = pop;

    assign ent_a[MAX_TERMS] = '0;
    assign vld_a[MAX_TERMS] = 1'b0;

    for (genvar i = 0; i < MAX_TERMS; i++) begin : g_cell
        stt_entry_t l_ent;
        logic       l_vld, l_gt;
        if (i == 0) begin : g_head
            assign l_ent = '0;
            assign l_vld = 1'b0;
            assign l_gt  = 1'b0;
        end else begin : g_body
            assign l_ent = ent_a[i-1];
            assign l_vld = vld_a[i-1];
            assign l_gt  = gt_a[i-1];
        end
        stt_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctrl        (ctrl),
            .new_ent     (new_ent),
            .left_ent    (l_ent),
            .left_valid  (l_vld),
            .left_gt     (l_gt),
            .right_ent   (ent_a[i+1]),
            .right_valid (vld_a[i+1]),
            .ent         (ent_a[i]),
            .valid       (vld_a[i]),
            .gt          (gt_a[i])
        );
        assign vld_vec[i] = vld_a[i];
    end

    // swap row and column on the way out
    assign m_tdata = {ent_a[0].value, ent_a[0].row, ent_a[0].col};
    assign m_tlast = !vld_a[1];

    always_comb begin
        phase_next = phase_reg;
        unique case (phase_reg)
            PH_LOAD: begin
                if (accept && s_tlast) begin
                    phase_next = PH_EMIT;
                end
            end
            PH_EMIT: begin
                if (!vld_a[0] || (pop && m_tlast)) begin
                    phase_next = PH_LOAD;
                end
            end
            default: phase_next = PH_LOAD;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_LOAD;
            matrix_cols_reg <= CFG_W'(1);
        end else begin
            phase_reg <= phase_next;
            if (cfg_wr_en) begin
                // row count has no effect on the transpose: discard it
                unique case (cfg_index)
                    REG_MATRIX_COLS: matrix_cols_reg <= cfg_wr_data;
                    default: ;
                endcase
            end
        end
    end

`ifndef SYNTHESIS
    a_no_load_while_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("input taken while results pending");

    a_chain_packed: assert property (@(posedge aclk) disable iff (!aresetn)
        (vld_vec & (vld_vec + 1'b1)) == '0)
        else $error("cell chain has a gap");

    a_drain_continues: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && !m_tlast) |=> m_tvalid)
        else $error("drain stopped before last result");

    a_last_ends_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && m_tlast) |=> (s_tready && vld_vec == '0))
        else $error("chain not empty after last result");
`endif

endmodule

`default_nettype wire
